### src/cmuxd_pkg.sv
// cmuxd_pkg: shared types, codes and the crc-8 step for the cmux deframer
// no dependencies; used by cmuxd_parser and cmux_basic_frame_deframer_top
`default_nettype none

package cmuxd_pkg;

    // counter width for the good and dropped frame counts
    localparam int unsigned COUNTER_WIDTH = 16;

    // framing constants
    localparam logic [7:0] FLAG_BYTE = 8'hF9;
    localparam logic [7:0] FCS_GOOD  = 8'hCF;
    localparam logic [7:0] FCS_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'hE0;
    localparam logic [7:0] UI_MASK   = 8'hEF;
    localparam logic [7:0] UI_CTRL   = 8'h03;

    // configuration register indexes and reset values
    localparam logic       CFG_NUM_CHANNELS = 1'b0;
    localparam logic       CFG_MAX_PAYLOAD  = 1'b1;
    localparam logic [6:0]  NUM_CHANNELS_RST = 7'd4;
    localparam logic [14:0] MAX_PAYLOAD_RST  = 15'd127;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CTRL = 3'd2,
        PH_LEN1 = 3'd3,
        PH_LEN2 = 3'd4,
        PH_DATA = 3'd5,
        PH_FCS  = 3'd6,
        PH_END  = 3'd7
    } phase_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_DROP    = 2'd2
    } kind_t;

    // drop reason codes
    typedef enum logic [2:0] {
        DROP_NONE     = 3'd0,
        DROP_CHANNEL  = 3'd1,
        DROP_TOO_LONG = 3'd2,
        DROP_FCS      = 3'd3,
        DROP_NO_FLAG  = 3'd4
    } drop_t;

    // one result beat
    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               payload_byte;
        logic [5:0]               channel;
        logic [7:0]               control_byte;
        logic [14:0]              frame_length;
        drop_t                    drop_reason;
        logic [COUNTER_WIDTH-1:0] good_frames;
        logic [COUNTER_WIDTH-1:0] dropped_frames;
    } result_t;

    // reflected crc-8 update for one byte
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/cmuxd_parser.sv
// cmuxd_parser: frame phase machine, crc check, config registers and counters
// depends on cmuxd_pkg; produces at most one result per accepted byte
`default_nettype none

module cmuxd_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 beat,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [14:0]          cfg_data,
    output logic                      res_valid,
    output cmuxd_pkg::result_t        res
);

    cmuxd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  fcs_reg, fcs_next;
    logic [5:0]  chan_reg, chan_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [14:0] len_reg, len_next;
    logic [14:0] left_reg, left_next;
    logic [cmuxd_pkg::COUNTER_WIDTH-1:0] good_reg, good_next;
    logic [cmuxd_pkg::COUNTER_WIDTH-1:0] drop_reg, drop_next;
    logic [6:0]  num_ch_reg;
    logic [14:0] max_pay_reg;

    logic [7:0]  crc_in;
    logic [14:0] left_dec;
    logic [14:0] len1;
    logic [14:0] len2;
    logic        is_flag;
    logic        do_drop;
    cmuxd_pkg::kind_t kind_c;
    cmuxd_pkg::drop_t reason_c;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ch_reg  <= cmuxd_pkg::NUM_CHANNELS_RST;
            max_pay_reg <= cmuxd_pkg::MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cmuxd_pkg::CFG_NUM_CHANNELS)
                num_ch_reg <= cfg_data[6:0];
            else
                max_pay_reg <= cfg_data;
        end
    end

    // shared terms
    assign crc_in   = cmuxd_pkg::crc_step(fcs_reg, rx_byte);
    assign left_dec = left_reg - 15'd1;
    assign len1     = {8'd0, rx_byte[7:1]};
    assign len2     = {rx_byte, len_reg[6:0]};
    assign is_flag  = (rx_byte == cmuxd_pkg::FLAG_BYTE);

    // phase machine and result selection
    always_comb
    begin
        phase_next = phase_reg;
        fcs_next   = fcs_reg;
        chan_next  = chan_reg;
        ctrl_next  = ctrl_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        good_next  = good_reg;
        drop_next  = drop_reg;
        res_valid  = 1'b0;
        do_drop    = 1'b0;
        kind_c     = cmuxd_pkg::KIND_PAYLOAD;
        reason_c   = cmuxd_pkg::DROP_NONE;

        unique case (phase_reg)
            cmuxd_pkg::PH_HUNT:
            begin
                if (is_flag)
                    phase_next = cmuxd_pkg::PH_ADDR;
            end
            cmuxd_pkg::PH_ADDR:
            begin
                if (!is_flag)
                begin
                    chan_next = rx_byte[7:2];
                    ctrl_next = 8'd0;
                    len_next  = 15'd0;
                    if ({1'b0, rx_byte[7:2]} >= num_ch_reg)
                    begin
                        do_drop    = 1'b1;
                        reason_c   = cmuxd_pkg::DROP_CHANNEL;
                        phase_next = cmuxd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        fcs_next   = cmuxd_pkg::crc_step(cmuxd_pkg::FCS_INIT, rx_byte);
                        phase_next = cmuxd_pkg::PH_CTRL;
                    end
                end
            end
            cmuxd_pkg::PH_CTRL:
            begin
                ctrl_next  = rx_byte;
                fcs_next   = crc_in;
                phase_next = cmuxd_pkg::PH_LEN1;
            end
            cmuxd_pkg::PH_LEN1, cmuxd_pkg::PH_LEN2:
            begin
                fcs_next = crc_in;
                len_next = (phase_reg == cmuxd_pkg::PH_LEN1) ? len1 : len2;
                if (phase_reg == cmuxd_pkg::PH_LEN1 && !rx_byte[0])
                    phase_next = cmuxd_pkg::PH_LEN2;
                else if (len_next > max_pay_reg)
                begin
                    do_drop    = 1'b1;
                    reason_c   = cmuxd_pkg::DROP_TOO_LONG;
                    phase_next = is_flag ? cmuxd_pkg::PH_ADDR : cmuxd_pkg::PH_HUNT;
                end
                else
                begin
                    left_next  = len_next;
                    phase_next = (len_next == 15'd0) ? cmuxd_pkg::PH_FCS : cmuxd_pkg::PH_DATA;
                end
            end
            cmuxd_pkg::PH_DATA:
            begin
                if ((ctrl_reg & cmuxd_pkg::UI_MASK) == cmuxd_pkg::UI_CTRL)
                    fcs_next = crc_in;
                left_next = left_dec;
                if (left_dec == 15'd0)
                    phase_next = cmuxd_pkg::PH_FCS;
                res_valid = 1'b1;
                kind_c    = cmuxd_pkg::KIND_PAYLOAD;
            end
            cmuxd_pkg::PH_FCS:
            begin
                fcs_next   = crc_in;
                phase_next = cmuxd_pkg::PH_END;
            end
            cmuxd_pkg::PH_END:
            begin
                if (fcs_reg != cmuxd_pkg::FCS_GOOD)
                begin
                    do_drop    = 1'b1;
                    reason_c   = cmuxd_pkg::DROP_FCS;
                    phase_next = is_flag ? cmuxd_pkg::PH_ADDR : cmuxd_pkg::PH_HUNT;
                end
                else if (!is_flag)
                begin
                    do_drop    = 1'b1;
                    reason_c   = cmuxd_pkg::DROP_NO_FLAG;
                    phase_next = cmuxd_pkg::PH_HUNT;
                end
                else
                begin
                    good_next  = good_reg + cmuxd_pkg::COUNTER_WIDTH'(1);
                    fcs_next   = cmuxd_pkg::FCS_INIT;
                    phase_next = cmuxd_pkg::PH_HUNT;
                    res_valid  = 1'b1;
                    kind_c     = cmuxd_pkg::KIND_GOOD;
                end
            end
            default:
            begin
                phase_next = cmuxd_pkg::PH_HUNT;
            end
        endcase

        // common drop handling
        if (do_drop)
        begin
            drop_next = drop_reg + cmuxd_pkg::COUNTER_WIDTH'(1);
            fcs_next  = cmuxd_pkg::FCS_INIT;
            res_valid = 1'b1;
            kind_c    = cmuxd_pkg::KIND_DROP;
        end
    end

    // result fields reflect the state after this byte
    always_comb
    begin
        res.kind           = kind_c;
        res.payload_byte   = (kind_c == cmuxd_pkg::KIND_PAYLOAD) ? rx_byte : 8'd0;
        res.channel        = chan_next;
        res.control_byte   = ctrl_next;
        res.frame_length   = len_next;
        res.drop_reason    = reason_c;
        res.good_frames    = good_next;
        res.dropped_frames = drop_next;
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cmuxd_pkg::PH_HUNT;
            fcs_reg   <= cmuxd_pkg::FCS_INIT;
            chan_reg  <= 6'd0;
            ctrl_reg  <= 8'd0;
            len_reg   <= 15'd0;
            left_reg  <= 15'd0;
            good_reg  <= '0;
            drop_reg  <= '0;
        end
        else if (beat)
        begin
            phase_reg <= phase_next;
            fcs_reg   <= fcs_next;
            chan_reg  <= chan_next;
            ctrl_reg  <= ctrl_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            good_reg  <= good_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

`default_nettype wire

### src/cmux_basic_frame_deframer_top.sv
// output: a result beat is registered in the output register, or in the skid entry while that register is held
// throughput: one byte per cycle; the output register plus one skid entry
// keep input flowing while a result waits, stall rises only when the skid is full
// reset: rst_n clears the phase to hunting, crc to 0xff, counters to zero,
// num_channels to 4 and max_payload to 127; no clearing pass
`default_nettype none

module cmux_basic_frame_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       payload_byte,
    output logic [5:0]       channel,
    output logic [7:0]       control_byte,
    output logic [14:0]      frame_length,
    output logic [2:0]       drop_reason,
    output logic [15:0]      good_frames,
    output logic [15:0]      dropped_frames
);

    logic               in_beat;
    logic               out_beat;
    logic               res_valid;
    cmuxd_pkg::result_t res;
    cmuxd_pkg::result_t main_reg;
    cmuxd_pkg::result_t skid_reg;
    logic               main_valid_reg;
    logic               skid_valid_reg;
    logic               push;

    assign in_stall = skid_valid_reg;
    assign in_beat  = in_valid && !in_stall;
    assign out_beat = main_valid_reg && !out_stall;
    assign push     = in_beat && res_valid;

    // frame parser
    cmuxd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (in_beat),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register and skid entry control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_beat)
                    skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                if (main_valid_reg && !out_beat)
                    skid_valid_reg <= 1'b1;
                else
                    main_valid_reg <= 1'b1;
            end
            else if (out_beat)
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    // output register and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_beat)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !out_beat)
                skid_reg <= res;
            else
                main_reg <= res;
        end
    end

    // result beat fields
    assign out_valid      = main_valid_reg;
    assign kind           = main_reg.kind;
    assign payload_byte   = main_reg.payload_byte;
    assign channel        = main_reg.channel;
    assign control_byte   = main_reg.control_byte;
    assign frame_length   = main_reg.frame_length;
    assign drop_reason    = main_reg.drop_reason;
    assign good_frames    = main_reg.good_frames;
    assign dropped_frames = main_reg.dropped_frames;

endmodule

`default_nettype wire
